// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the event-stream parser RTL.
// No dependencies; each use expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ESP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define ESP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// File: hw/rtl/esp_pkg.sv
// Shared types and constants of the event-stream line parser.
// No dependencies; used by esp_step, esp_outq and the top level.
`default_nettype none

package esp_pkg;

    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChSpace = 8'h20;

    // line phase codes
    localparam logic [2:0] PhStart    = 3'd0;
    localparam logic [2:0] PhName     = 3'd1;
    localparam logic [2:0] PhValFirst = 3'd2;
    localparam logic [2:0] PhVal      = 3'd3;
    localparam logic [2:0] PhSkip     = 3'd4;

    localparam logic [2:0] NameLen  = 3'd4;
    localparam logic [2:0] NameMiss = 3'd7;

    localparam logic [7:0] DataName [4] = '{8'h64, 8'h61, 8'h74, 8'h61};

    localparam logic KindData = 1'b0;
    localparam logic KindEnd  = 1'b1;

    // result queue; depth must be a power of two and at least two
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] pos;
        logic       cr_held;
        logic       has_data;
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_res;

    // results of one request, in order; cnt is 0, 1 or 2
    typedef struct packed {
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_push;

endpackage

`default_nettype wire

// File: hw/rtl/event_stream_line_parser_core.sv
// Top level of the event-stream line parser: state register, step logic, result queue.
// Depends on esp_pkg, esp_step, esp_outq and assert_macros.svh.
//
//   channel | signals                         | direction
//   input   | i_valid, o_ready, i_stream_byte | byte stream in
//   output  | o_valid, i_ready, o_item_kind,  | data bytes and end-of-event
//           | o_data_byte, o_last_of_run      | markers out
//
// One byte is taken per cycle while o_ready is high; its results go into the result queue and leave its head in order.
// A byte giving two results hands them out from the queue head one after the other.
// o_ready drops while the result queue holds more than QueueDepth-2 entries.
// Reset is synchronous, active low; it clears the parser state and empties the queue.
// Zero-result bytes (CR, comments, field names) put nothing into the result queue.
`default_nettype none
`include "assert_macros.svh"

module event_stream_line_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_stream_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_item_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last_of_run
);
    import esp_pkg::*;

    t_state r_state;
    t_state n_state;
    t_push  step_push;
    logic   accept;

    assign accept = i_valid && o_ready;

    esp_step u_step (
        .i_state (r_state),
        .i_byte  (i_stream_byte),
        .o_state (n_state),
        .o_push  (step_push)
    );

    // advance parser state only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= PhStart;
            r_state.pos      <= 3'd0;
            r_state.cr_held  <= 1'b0;
            r_state.has_data <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    esp_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (step_push),
        .o_room    (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_kind    (o_item_kind),
        .o_data    (o_data_byte),
        .o_last    (o_last_of_run)
    );

    `ESP_ASSERT(a_marker_alone, i_clk, i_rst_n,
        (step_push.cnt == 2'd2) |-> (step_push.res0.kind == KindData &&
                                     step_push.res1.kind == KindData))
    `ESP_ASSERT(a_marker_clears, i_clk, i_rst_n,
        (accept && step_push.cnt != 2'd0 && step_push.res0.kind == KindEnd)
            |=> !r_state.has_data)

endmodule

`default_nettype wire

// File: hw/rtl/esp_step.sv
// Next-state and result logic for one stream byte.
// Depends on esp_pkg.
`default_nettype none

module esp_step (
    input  esp_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    output esp_pkg::t_state o_state,
    output esp_pkg::t_push  o_push
);
    import esp_pkg::*;

    typedef struct packed {
        t_state st;
        logic   emit;
        t_res   res;
    } t_cstep;

    function automatic t_cstep content_step(input t_state s, input logic [7:0] b);
        t_cstep r;
        r.st       = s;
        r.emit     = 1'b0;
        r.res.kind = KindData;
        r.res.data = ChLf;
        unique case (s.phase) inside
            PhStart, PhName: begin
                if (s.phase == PhStart) begin
                    r.st.pos   = 3'd0;
                    r.st.phase = PhName;
                end
                if (b == ChColon) begin
                    if (r.st.pos == NameLen) begin
                        // separator before a further data line
                        r.emit     = s.has_data;
                        r.st.phase = PhValFirst;
                    end else begin
                        r.st.phase = PhSkip;
                    end
                end else if (r.st.pos < NameLen && b == DataName[r.st.pos[1:0]]) begin
                    r.st.pos = r.st.pos + 3'd1;
                end else begin
                    r.st.pos = NameMiss;
                end
            end
            PhValFirst: begin
                r.st.phase = PhVal;
                if (b != ChSpace) begin
                    r.emit        = 1'b1;
                    r.res.data    = b;
                    r.st.has_data = 1'b1;
                end
            end
            PhVal: begin
                r.emit        = 1'b1;
                r.res.data    = b;
                r.st.has_data = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_cstep line_end_step(input t_state s);
        t_cstep r;
        r.st       = s;
        r.emit     = 1'b0;
        r.res.kind = KindData;
        r.res.data = ChLf;
        if (s.phase == PhStart) begin
            if (s.has_data) begin
                r.emit        = 1'b1;
                r.res.kind    = KindEnd;
                r.res.data    = 8'h00;
                r.st.has_data = 1'b0;
            end
        end else if (s.phase == PhName && s.pos == NameLen) begin
            r.emit = s.has_data;
        end
        r.st.phase = PhStart;
        r.st.pos   = 3'd0;
        return r;
    endfunction

    t_state s0;
    t_cstep c_le;
    t_cstep c_plain;
    t_cstep c_cr;
    t_cstep c_after;
    t_cstep c_first;
    t_cstep c_second;
    t_cstep c_none;

    always_comb begin
        s0         = i_state;
        s0.cr_held = 1'b0;

        c_le    = line_end_step(s0);
        c_plain = content_step(s0, i_byte);
        c_cr    = content_step(s0, ChCr);
        c_after = content_step(c_cr.st, i_byte);

        c_none      = c_plain;
        c_none.st   = s0;
        c_none.emit = 1'b0;

        c_first  = c_none;
        c_second = c_none;
        o_state  = s0;

        if (i_state.cr_held) begin
            if (i_byte == ChLf) begin
                c_first = c_le;
                o_state = c_le.st;
            end else if (i_byte == ChCr) begin
                // held CR becomes content, the new CR is held in turn
                c_first         = c_cr;
                o_state         = c_cr.st;
                o_state.cr_held = 1'b1;
            end else begin
                c_first  = c_cr;
                c_second = c_after;
                o_state  = c_after.st;
            end
        end else if (i_byte == ChCr) begin
            o_state.cr_held = 1'b1;
        end else if (i_byte == ChLf) begin
            c_first = c_le;
            o_state = c_le.st;
        end else begin
            c_first = c_plain;
            o_state = c_plain.st;
        end

        // pack emitted results to the front
        if (c_first.emit) begin
            o_push.res0 = c_first.res;
            o_push.res1 = c_second.res;
            o_push.cnt  = c_second.emit ? 2'd2 : 2'd1;
        end else begin
            o_push.res0 = c_second.res;
            o_push.res1 = c_second.res;
            o_push.cnt  = c_second.emit ? 2'd1 : 2'd0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/esp_outq.sv
// Result queue: takes up to two results per request, hands out one a cycle while i_ready is high.
// Depends on esp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module esp_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_en,
    input  esp_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [7:0]     o_data,
    output logic           o_last
);
    import esp_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_entry;

    localparam logic [QueueAw:0] RoomLimit = (QueueAw + 1)'(QueueDepth - 2);
    localparam logic [QueueAw:0] FullCount = (QueueAw + 1)'(QueueDepth);

    t_entry               r_mem [QueueDepth];
    logic [QueueAw-1:0]   r_wptr;
    logic [QueueAw-1:0]   r_rptr;
    logic [QueueAw:0]     r_count;
    logic [QueueAw-1:0]   n_wptr;
    logic [QueueAw-1:0]   n_rptr;
    logic [QueueAw:0]     n_count;
    logic [1:0]           push_n;
    logic                 pop;
    t_entry               ent0;
    t_entry               ent1;

    assign push_n = i_push_en ? i_push.cnt : 2'd0;
    assign pop    = (r_count != '0) && i_ready;
    assign o_room = (r_count <= RoomLimit);

    always_comb begin
        ent0.kind = i_push.res0.kind;
        ent0.data = i_push.res0.data;
        ent0.last = (i_push.cnt == 2'd1);
        ent1.kind = i_push.res1.kind;
        ent1.data = i_push.res1.data;
        ent1.last = 1'b1;
        n_wptr    = r_wptr + QueueAw'(push_n);
        n_rptr    = r_rptr + QueueAw'(pop);
        n_count   = r_count + (QueueAw + 1)'(push_n) - (QueueAw + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wptr] <= ent0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wptr + QueueAw'(1)] <= ent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_kind  = r_mem[r_rptr].kind;
    assign o_data  = r_mem[r_rptr].data;
    assign o_last  = r_mem[r_rptr].last;

    `ESP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FullCount)
    `ESP_ASSERT(a_push_has_room, i_clk, i_rst_n, (push_n != 2'd0) |-> o_room)
    `ESP_ASSERT(a_head_holds, i_clk, i_rst_n,
        (o_valid && !i_ready) |=> (o_valid && $stable(o_kind) && $stable(o_data)))

endmodule

`default_nettype wire
